[rtl/bmpc_pkg.sv]
// bmpc_pkg: shared types and constants of the banded min-path cost accumulator.
// No dependencies; imported by the interfaces and all rtl modules.
package bmpc_pkg;

    localparam int COST_W = 32;   // signed Q23.8 cost
    localparam int ROW_W  = 10;   // row index and band bounds
    localparam int MD_W   = 5;    // row step limit register
    localparam int NPC_W  = 31;   // no_path_cost register
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = NPC_W;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_PATH_COST = 1'd1;

    localparam logic [MD_W-1:0]  ROW_STEP_RST     = 5'd5;
    localparam logic [NPC_W-1:0] NO_PATH_COST_RST = 31'h7FFF_FFFF;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic setup;
        logic scan;
        logic sum;
        logic emit;
        logic copy;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_band;
        logic any_pred;
        logic scan_last;
        logic out_free;
        logic col_end;
        logic copy_last;
    } t_sts;

endpackage

[rtl/bmpc_if.sv]
// bmpc_if: valid/ready channel interfaces for pixel transactions and result transactions.
// Depends on bmpc_pkg for field widths.
interface bmpc_in_if import bmpc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] pixel_cost;
    logic [ROW_W-1:0]         row_index;
    logic [ROW_W-1:0]         band_top;
    logic [ROW_W-1:0]         band_bottom;
    logic                     first_column;
    logic                     column_end;

    modport source (output valid, pixel_cost, row_index, band_top, band_bottom,
                    first_column, column_end, input ready);
    modport sink   (input valid, pixel_cost, row_index, band_top, band_bottom,
                    first_column, column_end, output ready);
endinterface

interface bmpc_out_if import bmpc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] path_cost;
    logic                     column_done;

    modport source (output valid, path_cost, column_done, input ready);
    modport sink   (input valid, path_cost, column_done, output ready);
endinterface

[rtl/bmpc_ctrl.sv]
// bmpc_ctrl: sequencer for one pixel transaction (setup, window scan, sum, emit, column copy).
// Depends on bmpc_pkg (t_cmd, t_sts).
module bmpc_ctrl import bmpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_SUM,
        S_EMIT,
        S_COPY
    } t_state;

    t_state r_state, n_state;
    logic   r_copy_end, n_copy_end;

    always_comb begin
        n_state    = r_state;
        n_copy_end = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                n_state = (i_sts.in_band && i_sts.any_pred) ? S_SCAN : S_SUM;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SUM;   // last read data lands in the min compare
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.col_end ? S_COPY : S_IDLE;
                end
            end
            S_COPY: begin
                // copy sweep; the r_copy_end pass lets the final prior write land
                if (r_copy_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.copy = 1'b1;
                    n_copy_end = i_sts.copy_last;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_copy_end <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_copy_end <= n_copy_end;
        end
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_cmd.in_ready)
        else $error("new transaction accepted while one is in work");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result emitted over a pending output");

    a_scan_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan |-> (i_sts.in_band && i_sts.any_pred))
        else $error("window scan without an in-band pixel");

endmodule

[rtl/bmpc_dp.sv]
// bmpc_dp: datapath with config registers, prior/current column memories, window min search,
// saturating add and output register. Depends on bmpc_pkg.
module bmpc_dp import bmpc_pkg::*; #(
    parameter int COLUMN_HEIGHT = 1024,
    parameter int MAX_DELTA     = 31
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [COST_W-1:0] i_pixel_cost,
    input  logic [ROW_W-1:0]         i_row_index,
    input  logic [ROW_W-1:0]         i_band_top,
    input  logic [ROW_W-1:0]         i_band_bottom,
    input  logic                     i_first_column,
    input  logic                     i_column_end,
    input  logic                     i_out_ready,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    output logic                     o_out_valid,
    output logic signed [COST_W-1:0] o_path_cost,
    output logic                     o_column_done
);

    localparam int AW = $clog2(COLUMN_HEIGHT);
    // compare width: holds row + delta and COLUMN_HEIGHT - 1
    localparam int CW = ((AW > ROW_W) ? AW : ROW_W) + 2;
    localparam logic [CW-1:0] LAST_ROW = CW'(COLUMN_HEIGHT - 1);
    localparam logic [CW-1:0] DMAX     = CW'(MAX_DELTA);
    localparam logic [AW-1:0] LAST_ADDR = AW'(COLUMN_HEIGHT - 1);

    // configuration
    logic [MD_W-1:0]  r_row_step;
    logic [NPC_W-1:0] r_no_path_cost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_step     <= ROW_STEP_RST;
            r_no_path_cost <= NO_PATH_COST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_STEP:     r_row_step     <= i_cfg_data[MD_W-1:0];
                REG_NO_PATH_COST: r_no_path_cost <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched transaction
    logic signed [COST_W-1:0] r_cost;
    logic [ROW_W-1:0]         r_row, r_top, r_bot;
    logic                     r_first, r_cend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cost  <= i_pixel_cost;
            r_row   <= i_row_index;
            r_top   <= i_band_top;
            r_bot   <= i_band_bottom;
            r_first <= i_first_column;
            r_cend  <= i_column_end;
        end
    end

    // prior column band
    logic [ROW_W-1:0] r_ptop, r_pbot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptop <= '0;
            r_pbot <= '0;
        end else if (i_cmd.emit && r_cend) begin
            r_ptop <= r_top;
            r_pbot <= r_bot;
        end
    end

    // window bounds
    logic [CW-1:0] w_row, w_md, w_d, w_lo0, w_lo, w_hi0, w_hi1, w_hi, w_ptop, w_pbot;
    logic          w_row_ok, w_in_band;

    always_comb begin
        w_row    = CW'(r_row);
        w_ptop   = CW'(r_ptop);
        w_pbot   = CW'(r_pbot);
        w_md     = CW'(r_row_step);
        w_d      = (w_md > DMAX) ? DMAX : w_md;
        w_lo0    = (w_row >= w_d) ? (w_row - w_d) : '0;
        w_lo     = (w_lo0 > w_ptop) ? w_lo0 : w_ptop;
        w_hi0    = w_row + w_d;
        w_hi1    = (w_hi0 > LAST_ROW) ? LAST_ROW : w_hi0;
        w_hi     = (w_hi1 < w_pbot) ? w_hi1 : w_pbot;
        w_row_ok = (w_row <= LAST_ROW);
        w_in_band = !r_first && w_row_ok && (r_row >= r_top) && (r_row <= r_bot);
    end

    logic [CW-1:0] r_k, r_hi;
    logic          r_in_band, r_any, r_row_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_k       <= w_lo;
            r_hi      <= w_hi;
            r_any     <= (w_lo <= w_hi);
            r_in_band <= w_in_band;
            r_row_ok  <= w_row_ok;
        end else if (i_cmd.scan) begin
            r_k <= r_k + CW'(1);
        end
    end

    // memories
    logic signed [COST_W-1:0] r_prior_mem [COLUMN_HEIGHT];
    logic signed [COST_W-1:0] r_cur_mem   [COLUMN_HEIGHT];
    logic signed [COST_W-1:0] r_rd, r_cd;
    logic                     r_rd_vld, r_cw_vld;
    logic [AW-1:0]            r_c, r_cw_addr;
    logic signed [COST_W-1:0] r_best, r_res;

    always_ff @(posedge i_clk) begin
        if (r_cw_vld) begin
            r_prior_mem[r_cw_addr] <= r_cd;
        end
        if (i_cmd.scan) begin
            r_rd <= r_prior_mem[r_k[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && r_row_ok) begin
            r_cur_mem[AW'(r_row)] <= r_res;
        end
        if (i_cmd.copy) begin
            r_cd <= r_cur_mem[r_c];
        end
    end

    // copy sweep counter and write-behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw_vld <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_cw_vld <= i_cmd.copy;
            r_rd_vld <= i_cmd.scan;
        end
        if (i_cmd.emit) begin
            r_c <= '0;
        end else if (i_cmd.copy) begin
            r_c <= r_c + AW'(1);
        end
        r_cw_addr <= r_c;
    end

    // running minimum and saturating add
    logic signed [COST_W:0] w_sum;
    logic signed [COST_W-1:0] w_sat;

    always_comb begin
        w_sum = {r_cost[COST_W-1], r_cost} + {r_best[COST_W-1], r_best};
        if (w_sum[COST_W] != w_sum[COST_W-1]) begin
            w_sat = w_sum[COST_W] ? {1'b1, {(COST_W-1){1'b0}}} : {1'b0, {(COST_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[COST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_best <= $signed({1'b0, r_no_path_cost});
        end else if (r_rd_vld && (r_rd < r_best)) begin
            r_best <= r_rd;
        end
        if (i_cmd.sum) begin
            r_res <= r_in_band ? w_sat : r_cost;
        end
    end

    // output register
    logic                     r_ovld;
    logic signed [COST_W-1:0] r_opath;
    logic                     r_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_opath <= r_res;
            r_ocol  <= r_cend;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_path_cost   = r_opath;
    assign o_column_done = r_ocol;

    always_comb begin
        o_sts.in_band   = r_in_band;
        o_sts.any_pred  = r_any;
        o_sts.scan_last = (r_k == r_hi);
        o_sts.out_free  = !r_ovld || i_out_ready;
        o_sts.col_end   = r_cend;
        o_sts.copy_last = (r_c == LAST_ADDR);
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_k <= r_hi))
        else $error("window scan past its upper bound");

    a_copy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cw_vld |-> !i_cmd.load)
        else $error("transaction accepted during column copy");

endmodule

[rtl/banded_min_path_cost_accumulator_unit.sv]
// Sequence: accept, setup, band check; outside the band or with no predecessor, then sum;
// inside it, first a scan of the n >= 1 prior-column window rows (up to 2*MAX_DELTA+1)
// and a drain step; emit waits for a free output. Throughput: one transaction at a time; the
// next is taken in the cycle after the result is registered, or after the copy sweep that
// a column_end adds. The window min reads one prior-column memory entry per cycle.
// Reset (sync, active low) restores row step 5, no_path_cost max, prior band zero.
module banded_min_path_cost_accumulator_unit import bmpc_pkg::*; #(
    parameter int COLUMN_HEIGHT = 1024,
    parameter int MAX_DELTA     = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bmpc_in_if.sink               i_in,
    bmpc_out_if.source            o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    // controller: one transaction through setup, scan, sum, emit and copy
    bmpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // ready only in idle; the output register decouples the sink
    assign i_in.ready = w_cmd.in_ready;

    bmpc_dp #(
        .COLUMN_HEIGHT (COLUMN_HEIGHT),
        .MAX_DELTA     (MAX_DELTA)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_cost   (i_in.pixel_cost),
        .i_row_index    (i_in.row_index),
        .i_band_top     (i_in.band_top),
        .i_band_bottom  (i_in.band_bottom),
        .i_first_column (i_in.first_column),
        .i_column_end   (i_in.column_end),
        .i_out_ready    (o_out.ready),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_out.valid),
        .o_path_cost    (o_out.path_cost),
        .o_column_done  (o_out.column_done)
    );

endmodule
